[hw/rtl/acard_pkg.sv]
package acard_pkg;

  // Defaults for the top-level parameters
  localparam int CARDS_DEF      = 16;
  localparam int UID_BYTES_DEF  = 5;
  localparam int NAME_BYTES_DEF = 8;

  // Fixed field widths on the ports
  localparam int CMD_W    = 3;
  localparam int NAME_FW  = 64;
  localparam int ID_FW    = 32;
  localparam int UID_FW   = 40;
  localparam int IDX_FW   = 4;
  localparam int STATUS_W = 2;
  localparam int SLOT_FW  = 4;
  localparam int COUNT_FW = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_INSERT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_UPDATE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ    = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // Source of the card fields in a result
  localparam logic [1:0] CARD_ZERO = 2'd0;
  localparam logic [1:0] CARD_HOLD = 2'd1;
  localparam logic [1:0] CARD_UPD  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                load;
    logic                scan;
    logic                capture;
    logic                read_idx;
    logic                start_shift;
    logic                shift;
    logic                wr_ins;
    logic                wr_upd;
    logic                inc_count;
    logic                dec_count;
    logic                emit;
    logic [STATUS_W-1:0] res_status;
    logic [1:0]          res_card;
    logic                res_slot;
  } acard_ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             full;
    logic             empty;
    logic             idx_ok;
    logic             hit;
    logic             walk_done;
    logic             out_free;
  } acard_sts_t;

endpackage

[hw/rtl/acard_ram.sv]
module acard_ram import acard_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = CARDS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/acard_ctrl.sv]
module acard_ctrl import acard_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_stall,
  input  acard_sts_t sts,
  output acard_ctl_t ctl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_SHIFT = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;
  logic [1:0]          res_card;
  logic [1:0]          res_card_next;
  logic                res_slot;
  logic                res_slot_next;

  // Take a new item only when idle
  assign cmd_stall = (state != S_IDLE);

  // Sequence one command
  always_comb begin
    ctl             = '0;
    state_next      = state;
    res_status_next = res_status;
    res_card_next   = res_card;
    res_slot_next   = res_slot;
    ctl.res_status  = res_status;
    ctl.res_card    = res_card;
    ctl.res_slot    = res_slot;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load   = 1'b1;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        res_status_next = ST_OK;
        res_card_next   = CARD_ZERO;
        res_slot_next   = 1'b0;
        state_next      = S_EMIT;
        case (sts.op)
          CMD_INSERT: begin
            if (sts.full) begin
              res_status_next = ST_FULL;
            end else begin
              ctl.wr_ins    = 1'b1;
              ctl.inc_count = 1'b1;
            end
          end
          CMD_DEQUEUE: begin
            if (sts.empty) begin
              res_status_next = ST_EMPTY;
            end else begin
              state_next = S_SCAN;
            end
          end
          CMD_LOOKUP, CMD_REMOVE, CMD_UPDATE: begin
            state_next = S_SCAN;
          end
          CMD_READ: begin
            if (sts.idx_ok) begin
              ctl.read_idx = 1'b1;
              state_next   = S_READ;
            end else begin
              res_status_next = ST_NOTFOUND;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN: begin
        if (sts.hit) begin
          ctl.capture     = 1'b1;
          res_card_next   = CARD_HOLD;
          res_slot_next   = 1'b1;
          case (sts.op)
            CMD_LOOKUP: begin
              state_next = S_EMIT;
            end
            CMD_UPDATE: begin
              ctl.wr_upd    = 1'b1;
              res_card_next = CARD_UPD;
              state_next    = S_EMIT;
            end
            default: begin
              ctl.start_shift = 1'b1;
              state_next      = S_SHIFT;
            end
          endcase
        end else if (sts.walk_done) begin
          res_status_next = ST_NOTFOUND;
          state_next      = S_EMIT;
        end else begin
          ctl.scan = 1'b1;
        end
      end
      S_READ: begin
        ctl.capture   = 1'b1;
        res_card_next = CARD_HOLD;
        res_slot_next = 1'b1;
        state_next    = S_EMIT;
      end
      S_SHIFT: begin
        if (sts.walk_done) begin
          ctl.dec_count = 1'b1;
          state_next    = S_EMIT;
        end else begin
          ctl.shift = 1'b1;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result selection, held until the result is loaded
  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_card   <= res_card_next;
    res_slot   <= res_slot_next;
  end

`ifndef SYNTHESIS
  a_load_to_disp: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_valid) |=> (state == S_DISP))
    else $error("accepted item did not move to dispatch");
`endif

endmodule

[hw/rtl/acard_dpath.sv]
module acard_dpath import acard_pkg::*; #(
  parameter int CARDS      = CARDS_DEF,
  parameter int UID_BYTES  = UID_BYTES_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  acard_ctl_t          ctl,
  output acard_sts_t          sts,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [NAME_FW-1:0]  name_text,
  input  logic [ID_FW-1:0]    card_id,
  input  logic [UID_FW-1:0]   card_uuid,
  input  logic [IDX_FW-1:0]   slot_index,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_FW-1:0]  found_slot,
  output logic [NAME_FW-1:0]  out_name,
  output logic [ID_FW-1:0]    out_id,
  output logic [UID_FW-1:0]   out_uuid,
  output logic [COUNT_FW-1:0] entry_count
);

  localparam int NAME_W = NAME_BYTES * 8;
  localparam int UID_W  = (UID_BYTES * 8 > UID_FW) ? UID_FW : UID_BYTES * 8;
  localparam int WORD_W = NAME_W + ID_FW + UID_W;
  localparam int SW     = $clog2(CARDS);
  localparam int CW     = $clog2(CARDS + 1);
  localparam int CMPW   = (CW > IDX_FW) ? CW : IDX_FW;

  logic [CMD_W-1:0]  op_q;
  logic [NAME_W-1:0] name_q;
  logic [ID_FW-1:0]  id_q;
  logic [UID_W-1:0]  uid_q;
  logic [IDX_FW-1:0] idx_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;
  logic              rd_pend;
  logic [SW-1:0]     rd_slot;
  logic [SW-1:0]     hit_slot;
  logic [NAME_W-1:0] hold_name;
  logic [ID_FW-1:0]  hold_id;
  logic [UID_W-1:0]  hold_uid;

  logic              ram_we;
  logic [SW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [SW-1:0]     ram_raddr;
  logic [WORD_W-1:0] rd_word;
  logic [NAME_W-1:0] rd_name;
  logic [ID_FW-1:0]  rd_id;
  logic [UID_W-1:0]  rd_uid;
  logic              match;
  logic              ptr_in;
  logic              out_free;

  // Card store: name, id and uid packed in one word per slot
  acard_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CARDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_word)
  );

  assign rd_name = rd_word[WORD_W-1 -: NAME_W];
  assign rd_id   = rd_word[UID_W +: ID_FW];
  assign rd_uid  = rd_word[UID_W-1:0];
  assign ptr_in  = (ptr < count);

  // Key compare on the word just read
  always_comb begin
    case (op_q)
      CMD_DEQUEUE: match = 1'b1;
      CMD_REMOVE:  match = (rd_id == id_q);
      default:     match = (rd_uid == uid_q);
    endcase
  end

  assign out_free = !rsp_valid || !rsp_stall;

  // Status to the controller
  always_comb begin
    sts.op        = op_q;
    sts.full      = (count == CW'(CARDS));
    sts.empty     = (count == '0);
    sts.idx_ok    = (CMPW'(idx_q) < CMPW'(count));
    sts.hit       = rd_pend && match;
    sts.walk_done = !rd_pend && !ptr_in;
    sts.out_free  = out_free;
  end

  // Read port: walk pointer or requested slot
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr[SW-1:0];
    if (ctl.read_idx) begin
      ram_re    = 1'b1;
      ram_raddr = SW'(idx_q);
    end else if (ctl.scan || ctl.shift) begin
      ram_re = ptr_in;
    end
  end

  // Write port: append, rewrite, or move a card down one slot
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[SW-1:0];
    ram_wdata = {name_q, id_q, uid_q};
    if (ctl.wr_ins) begin
      ram_we = 1'b1;
    end else if (ctl.wr_upd) begin
      ram_we    = 1'b1;
      ram_waddr = rd_slot;
    end else if (ctl.shift && rd_pend) begin
      ram_we    = 1'b1;
      ram_waddr = rd_slot - 1'b1;
      ram_wdata = rd_word;
    end
  end

  // Latch the item's fields, masked to the stored widths
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_q   <= cmd;
      name_q <= name_text[NAME_W-1:0];
      id_q   <= card_id;
      uid_q  <= card_uuid[UID_W-1:0];
      idx_q  <= slot_index;
    end
  end

  // Walk pointer
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      ptr <= '0;
    end else if (ctl.start_shift) begin
      ptr <= CW'(rd_slot) + 1'b1;
    end else if ((ctl.scan || ctl.shift) && ptr_in) begin
      ptr <= ptr + 1'b1;
    end
  end

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else if (ctl.load || ctl.start_shift) begin
      rd_pend <= 1'b0;
    end else if (ctl.scan || ctl.shift) begin
      rd_pend <= ptr_in;
    end else if (ctl.read_idx) begin
      rd_pend <= 1'b1;
    end else if (ctl.capture) begin
      rd_pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan || ctl.shift) begin
      rd_slot <= ptr[SW-1:0];
    end else if (ctl.read_idx) begin
      rd_slot <= SW'(idx_q);
    end
  end

  // Hold the returned card
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      hold_name <= rd_name;
      hold_id   <= rd_id;
      hold_uid  <= rd_uid;
      hit_slot  <= rd_slot;
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.inc_count) begin
      count <= count + 1'b1;
    end else if (ctl.dec_count) begin
      count <= count - 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctl.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status      <= ctl.res_status;
      found_slot  <= ctl.res_slot ? SLOT_FW'(hit_slot) : '0;
      entry_count <= COUNT_FW'(count);
      case (ctl.res_card)
        CARD_HOLD: begin
          out_name <= NAME_FW'(hold_name);
          out_id   <= hold_id;
          out_uuid <= UID_FW'(hold_uid);
        end
        CARD_UPD: begin
          out_name <= NAME_FW'(name_q);
          out_id   <= id_q;
          out_uuid <= UID_FW'(uid_q);
        end
        default: begin
          out_name <= '0;
          out_id   <= '0;
          out_uuid <= '0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CARDS))
    else $error("card count beyond table size");
  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_ins |-> (count < CW'(CARDS)))
    else $error("append into a full table");
  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.dec_count |-> (count != '0))
    else $error("removal from an empty table");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    ctl.emit |-> (!rsp_valid || !rsp_stall))
    else $error("result overwrites one not yet taken");
`endif

endmodule

[hw/rtl/authorized_card_table.sv]
// Authorized card table: a compact table of cards (name word, id, uid) held
// in slots 0 .. count-1 of one on-chip RAM.
// Command channel: cmd_valid / cmd_stall with cmd, name_text, card_id,
// card_uuid and slot_index. An item is taken when cmd_valid is high and
// cmd_stall low; cmd_stall is high while a command is in progress.
// Result channel: rsp_valid / rsp_stall with status, found_slot, out_name,
// out_id, out_uuid and entry_count; exactly one result per command.
// Insert, unknown codes and commands refused at once (table full, table empty,
// slot out of range) go straight from dispatch to the result; read slot
// reads the requested slot; lookup and update read the RAM one slot per cycle;
// remove and dequeue search up to the match and then move each later card
// down one slot per cycle.
// One command is in flight at a time; the next item is taken the cycle after
// the result is loaded.
// A result waits in the output register while rsp_stall is high; the next
// command is taken and worked meanwhile and only its own result waits.
// Reset empties the table at once by clearing the fill count; slots at or
// above the count are never read, so no clearing pass is needed.
module authorized_card_table import acard_pkg::*; #(
  parameter int CARDS      = CARDS_DEF,
  parameter int UID_BYTES  = UID_BYTES_DEF,
  parameter int NAME_BYTES = NAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [NAME_FW-1:0]  name_text,
  input  logic [ID_FW-1:0]    card_id,
  input  logic [UID_FW-1:0]   card_uuid,
  input  logic [IDX_FW-1:0]   slot_index,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_FW-1:0]  found_slot,
  output logic [NAME_FW-1:0]  out_name,
  output logic [ID_FW-1:0]    out_id,
  output logic [UID_FW-1:0]   out_uuid,
  output logic [COUNT_FW-1:0] entry_count
);

  acard_ctl_t ctl;
  acard_sts_t sts;

  // Command sequencer
  acard_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  // Card store, search and result register
  acard_dpath #(
    .CARDS      (CARDS),
    .UID_BYTES  (UID_BYTES),
    .NAME_BYTES (NAME_BYTES)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cmd         (cmd),
    .name_text   (name_text),
    .card_id     (card_id),
    .card_uuid   (card_uuid),
    .slot_index  (slot_index),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .found_slot  (found_slot),
    .out_name    (out_name),
    .out_id      (out_id),
    .out_uuid    (out_uuid),
    .entry_count (entry_count)
  );

endmodule
